[src/ragmt_pkg.sv]
package ragmt_pkg;

   localparam int LEAVES     = 1024;
   localparam int LOG_LEAVES = $clog2(LEAVES);
   localparam int NODE_W     = LOG_LEAVES + 1;
   localparam int LVL_W      = $clog2(LOG_LEAVES + 1);
   localparam int POS_W      = 10;
   localparam int AMT_W      = 16;
   localparam int VAL_W      = 32;
   localparam int CMP_W      = (POS_W > LOG_LEAVES) ? POS_W : LOG_LEAVES;
   localparam int REQ_W      = 40;
   localparam int RSP_W      = 40;

   typedef struct packed {
      logic [POS_W-1:0] range_start;
      logic [POS_W-1:0] range_end;
      logic [VAL_W-1:0] amount;
      logic             active;
   } item_type;

   // signed overflow of a 32-bit two's complement add
   function automatic logic add_ovf(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
      logic [VAL_W-1:0] s;
      s = a + b;
      return (a[VAL_W-1] == b[VAL_W-1]) && (s[VAL_W-1] != a[VAL_W-1]);
   endfunction

endpackage

[src/ragmt_front.sv]
module ragmt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       hold,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [ragmt_pkg::REQ_W-1:0] req_tdata,
   output logic                       q_valid,
   input  logic                       q_ready,
   output ragmt_pkg::item_type        q_item
);
   import ragmt_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   cls;
   logic       push, pop;

   // classify: a zero amount or an empty range touches no node
   always_comb begin
      cls.range_start = req_tdata[POS_W-1:0];
      cls.range_end   = req_tdata[2*POS_W-1:POS_W];
      cls.amount      = VAL_W'($signed(req_tdata[2*POS_W+AMT_W-1:2*POS_W]));
      cls.active      = (req_tdata[2*POS_W+AMT_W-1:2*POS_W] != '0) &&
                        (cls.range_start <= cls.range_end);
   end

   assign req_tready = (cnt_ff != 2'd2) && !hold;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

[src/ragmt_engine.sv]
module ragmt_engine (
   input  logic                        clock,
   input  logic                        reset,
   output logic                        clearing,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  ragmt_pkg::item_type         q_item,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ragmt_pkg::RSP_W-1:0] rsp_tdata
);
   import ragmt_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD_NODE, S_PUSH, S_CA_RD0, S_CA_WR0, S_CA_WR1,
      S_CHECK, S_RET, S_CMB_RD0, S_CMB_RD1, S_CMB_WR, S_DONE
   } state_type;

   logic [VAL_W-1:0] mx_mem [2*LEAVES];
   logic [VAL_W-1:0] pd_mem [2*LEAVES];
   logic [VAL_W-1:0] mx_rd_ff, pd_rd_ff;

   state_type        state_ff, state_in, cont_ff, cont_in;
   logic [NODE_W-1:0] clr_ff, clr_in, n_ff, n_in;
   logic [LVL_W-1:0] d_ff, d_in;
   item_type         item_ff, item_in;
   logic             fin_ff, fin_in, ovf_ff, ovf_in;
   logic [VAL_W-1:0] cur_ff, cur_in, add_ff, add_in, left_ff, left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_max_ff, rsp_max_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic [NODE_W-1:0] ra, mx_wa, pd_wa, kid0, kid1;
   logic              mx_we, pd_we;
   logic [VAL_W-1:0]  mx_wd, pd_wd, psum, csum, ksum;
   logic              leaf, disjoint, covered;
   logic [2*LOG_LEAVES:0] shl;
   logic [LOG_LEAVES-1:0] lo, hi;
   logic [CMP_W-1:0]  lo_c, hi_c, a_c, b_c;

   assign kid0 = {n_ff[NODE_W-2:0], 1'b0};
   assign kid1 = {n_ff[NODE_W-2:0], 1'b1};
   assign leaf = (d_ff == LVL_W'(LOG_LEAVES));

   // span of node n at depth d in a perfect tree
   always_comb begin
      shl      = {LOG_LEAVES'(0), n_ff} << (LVL_W'(LOG_LEAVES) - d_ff);
      lo       = shl[LOG_LEAVES-1:0];
      hi       = lo | ({LOG_LEAVES{1'b1}} >> d_ff);
      lo_c     = CMP_W'(lo);
      hi_c     = CMP_W'(hi);
      a_c      = CMP_W'(item_ff.range_start);
      b_c      = CMP_W'(item_ff.range_end);
      disjoint = (b_c < lo_c) || (hi_c < a_c);
      covered  = (a_c <= lo_c) && (hi_c <= b_c);
      psum     = mx_rd_ff + pd_rd_ff;
      csum     = cur_ff + item_ff.amount;
      ksum     = pd_rd_ff + add_ff;
   end

   assign clearing   = (state_ff == S_CLEAR);
   assign q_ready    = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-VAL_W-1){1'b0}}, rsp_ovf_ff, rsp_max_ff};

   always_comb begin
      state_in     = state_ff;
      cont_in      = cont_ff;
      clr_in       = clr_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      item_in      = item_ff;
      fin_in       = fin_ff;
      ovf_in       = ovf_ff;
      cur_in       = cur_ff;
      add_in       = add_ff;
      left_in      = left_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ra    = n_ff;
      mx_we = 1'b0;
      mx_wa = n_ff;
      mx_wd = '0;
      pd_we = 1'b0;
      pd_wa = n_ff;
      pd_wd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            mx_we  = 1'b1;
            mx_wa  = clr_ff;
            pd_we  = 1'b1;
            pd_wa  = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == {NODE_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               item_in  = q_item;
               n_in     = NODE_W'(1);
               d_in     = '0;
               fin_in   = !q_item.active;
               state_in = S_RD_NODE;
            end
         end
         S_RD_NODE: begin
            state_in = S_PUSH;
         end
         S_PUSH: begin
            // push the pending add into this node and its children
            if (pd_rd_ff != '0) begin
               mx_we  = 1'b1;
               mx_wd  = psum;
               pd_we  = 1'b1;
               ovf_in = ovf_ff | add_ovf(mx_rd_ff, pd_rd_ff);
               cur_in = psum;
               add_in = pd_rd_ff;
               cont_in = fin_ff ? S_DONE : S_CHECK;
               if (leaf) begin
                  state_in = fin_ff ? S_DONE : S_CHECK;
               end else begin
                  state_in = S_CA_RD0;
               end
            end else begin
               cur_in   = mx_rd_ff;
               state_in = fin_ff ? S_DONE : S_CHECK;
            end
         end
         S_CA_RD0: begin
            ra       = kid0;
            state_in = S_CA_WR0;
         end
         S_CA_WR0: begin
            pd_we    = 1'b1;
            pd_wa    = kid0;
            pd_wd    = ksum;
            ovf_in   = ovf_ff | add_ovf(pd_rd_ff, add_ff);
            ra       = kid1;
            state_in = S_CA_WR1;
         end
         S_CA_WR1: begin
            pd_we    = 1'b1;
            pd_wa    = kid1;
            pd_wd    = ksum;
            ovf_in   = ovf_ff | add_ovf(pd_rd_ff, add_ff);
            state_in = cont_ff;
         end
         S_CHECK: begin
            priority if (disjoint) begin
               state_in = S_RET;
            end else if (covered) begin
               mx_we   = 1'b1;
               mx_wd   = csum;
               ovf_in  = ovf_ff | add_ovf(cur_ff, item_ff.amount);
               cur_in  = csum;
               add_in  = item_ff.amount;
               cont_in = S_RET;
               state_in = leaf ? S_RET : S_CA_RD0;
            end else begin
               n_in     = kid0;
               d_in     = d_ff + 1'b1;
               state_in = S_RD_NODE;
            end
         end
         S_RET: begin
            priority if (n_ff == NODE_W'(1)) begin
               // tree walk done: final push at the root
               fin_in   = 1'b1;
               state_in = S_RD_NODE;
            end else if (!n_ff[0]) begin
               n_in     = n_ff + 1'b1;
               state_in = S_RD_NODE;
            end else begin
               n_in     = n_ff >> 1;
               d_in     = d_ff - 1'b1;
               state_in = S_CMB_RD0;
            end
         end
         S_CMB_RD0: begin
            ra       = kid0;
            state_in = S_CMB_RD1;
         end
         S_CMB_RD1: begin
            left_in  = mx_rd_ff;
            ra       = kid1;
            state_in = S_CMB_WR;
         end
         S_CMB_WR: begin
            mx_we    = 1'b1;
            mx_wd    = ($signed(left_ff) >= $signed(mx_rd_ff)) ? left_ff : mx_rd_ff;
            state_in = S_RET;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = cur_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mx_we) begin
         mx_mem[mx_wa] <= mx_wd;
      end
      mx_rd_ff <= mx_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (pd_we) begin
         pd_mem[pd_wa] <= pd_wd;
      end
      pd_rd_ff <= pd_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cont_ff      <= S_CHECK;
         clr_ff       <= '0;
         n_ff         <= NODE_W'(1);
         d_ff         <= '0;
         fin_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cont_ff      <= cont_in;
         clr_ff       <= clr_in;
         n_ff         <= n_in;
         d_ff         <= d_in;
         fin_ff       <= fin_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff    <= item_in;
      cur_ff     <= cur_in;
      add_ff     <= add_in;
      left_ff    <= left_in;
      rsp_max_ff <= rsp_max_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

`ifndef SYNTHESIS
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff) else $error("overflow flag dropped");
   a_combine_inner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMB_WR) |-> (d_ff < LVL_W'(LOG_LEAVES)))
      else $error("combine at leaf level");
   a_node_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD_NODE) |-> ((n_ff >> d_ff) == NODE_W'(1)))
      else $error("node index off its level");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> (state_ff == S_RD_NODE))
      else $error("popped word not started");
`endif

endmodule

[src/range_add_global_max_tree.sv]
// channel | dir | tdata fields (low bit up)                          | tuser
// req     | in  | range_start[9:0] range_end[19:10] add_amount[35:20] | -
// rsp     | out | overall_max[31:0] overflow_seen[32]                 | -
// An item walks the segment tree held in two single-port-write memories: per
// visited node a read, push of the pending add (a read and a write for each
// child) and, for split nodes, a merge that reads both children and writes the
// larger. A zero amount or empty range only does the final push at the root;
// a range update visits at most 4 nodes per level. After reset a clearing pass
// over all 2*LEAVES node entries runs with req_tready low. A two-word input
// queue and an output register let either side stall without stopping the other.
module range_add_global_max_tree (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ragmt_pkg::REQ_W-1:0] req_tdata,  // range_start, range_end, add_amount
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ragmt_pkg::RSP_W-1:0] rsp_tdata   // overall_max, overflow_seen
);
   import ragmt_pkg::*;

   logic     hold, q_valid, q_ready;
   item_type q_item;

   ragmt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (hold),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   ragmt_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .clearing   (hold),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
